@@ design/edf_pkg.sv @@
// ----------------------------------------------------------------------------
// EDF scheduler package
// Shared widths, state codes, command codes and the item structs.
// ----------------------------------------------------------------------------
package edf_pkg;

  localparam int NUM_TASKS_DEF = 8;
  localparam int CMD_W         = 3;
  localparam int TIME_W        = 32;
  localparam int STEP_W        = 16;
  localparam int OUT_ID_W      = 3;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;

  localparam logic [STEP_W-1:0] TICK_STEP_RST = 16'd10;

  // Task status codes
  localparam logic [1:0] ST_UNUSED   = 2'd0;
  localparam logic [1:0] ST_READY    = 2'd1;
  localparam logic [1:0] ST_RELEASED = 2'd2;
  localparam logic [1:0] ST_WAITING  = 2'd3;

  // Task placement codes
  localparam logic [1:0] PL_NONE   = 2'd0;
  localparam logic [1:0] PL_FIFO   = 2'd1;
  localparam logic [1:0] PL_WAIT   = 2'd2;
  localparam logic [1:0] PL_EREADY = 2'd3;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CREATE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SETP   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WAIT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_EXIT   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_YIELD  = 3'd5;

  // Register indexes
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_STEP   = 1'b1;

  typedef struct packed {
    logic              tick;
    logic              create;
    logic              set_period;
    logic              wait_period;
    logic              do_exit;
    logic              yield;
    logic              no_op;
    logic [TIME_W-1:0] period;
  } cmd_t;

  typedef struct packed {
    logic                active_valid;
    logic [OUT_ID_W-1:0] active_id;
    logic                switched;
    logic                deadline_missed;
    logic                create_ok;
    logic [OUT_ID_W-1:0] created_id;
    logic [TIME_W-1:0]   now_time;
    logic                command_error;
  } res_t;

endpackage

@@ design/edf_ram.sv @@
// ----------------------------------------------------------------------------
// EDF generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module edf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/edf_front.sv @@
// ----------------------------------------------------------------------------
// EDF command front end
// Accepts commands, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module edf_front
  import edf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [TIME_W-1:0] period,
  output logic              full,
  output logic              item_valid,
  output cmd_t              item,
  input  logic              item_pop
);

  cmd_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       dec;
  logic       do_push, do_pop;

  always_comb begin
    dec        = '0;
    dec.period = period;
    case (cmd)
      CMD_TICK:   dec.tick        = 1'b1;
      CMD_CREATE: dec.create      = 1'b1;
      CMD_SETP:   dec.set_period  = 1'b1;
      CMD_WAIT:   dec.wait_period = 1'b1;
      CMD_EXIT:   dec.do_exit     = 1'b1;
      CMD_YIELD:  dec.yield       = 1'b1;
      default:    dec.no_op       = 1'b1;
    endcase
  end

  assign full       = (cnt_r == 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign item       = ent_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = item_pop && item_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= dec;
    end
  end

endmodule

@@ design/edf_back.sv @@
// ----------------------------------------------------------------------------
// EDF scheduling engine
// Executes decoded commands one at a time and holds one result.
// ----------------------------------------------------------------------------
module edf_back
  import edf_pkg::*;
#(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  cmd_t              item,
  output logic              item_pop,
  input  logic              enabled,
  input  logic [STEP_W-1:0] step,
  output logic              res_valid,
  output res_t              res,
  input  logic              res_pop
);

  localparam int IW = $clog2(NUM_TASKS);
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] N_C  = CW'(NUM_TASKS);
  localparam logic [CW:0]   N_C2 = (CW+1)'(NUM_TASKS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WRD  = 5'b00010,
    S_PUT  = 5'b00100,
    S_SCAN = 5'b01000,
    S_END  = 5'b10000
  } state_t;

  state_t            st_r, st_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [TIME_W-1:0] stamp_r, stamp_nxt;
  logic [1:0]        status_r [NUM_TASKS];
  logic [1:0]        status_nxt [NUM_TASKS];
  logic [1:0]        place_r [NUM_TASKS];
  logic [1:0]        place_nxt [NUM_TASKS];
  logic [IW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              run_v_r, run_v_nxt;
  logic [IW-1:0]     run_id_r, run_id_nxt;
  logic [NUM_TASKS-1:0] vper_r, vper_nxt, vdue_r, vdue_nxt;
  logic [NUM_TASKS-1:0] vstp_r, vstp_nxt, vff_r, vff_nxt;
  logic [CW-1:0]     scan_r, scan_nxt;
  logic              cmp_v_r, cmp_v_nxt;
  logic [IW-1:0]     cmp_id_r, cmp_id_nxt;
  logic              mode_w_r, mode_w_nxt;
  logic              rel_r, rel_nxt;
  logic              best_f_r, best_f_nxt;
  logic [IW-1:0]     best_id_r, best_id_nxt;
  logic [TIME_W-1:0] best_due_r, best_due_nxt;
  logic [TIME_W-1:0] best_per_r, best_per_nxt;
  logic [TIME_W-1:0] best_stp_r, best_stp_nxt;
  logic              sw_r, sw_nxt, miss_r, miss_nxt;
  logic              cok_r, cok_nxt, err_r, err_nxt;
  logic [IW-1:0]     cid_r, cid_nxt;
  logic              out_v_r, out_v_nxt;
  res_t              out_r, out_nxt;
  logic              per_ok_r, due_ok_r, stp_ok_r, ff_ok_r;

  logic              re, ff_re, fin;
  logic [IW-1:0]     raddr;
  logic              per_we, due_we, stp_we, ff_we;
  logic [IW-1:0]     per_wa, due_wa, stp_wa, ff_wa;
  logic [TIME_W-1:0] per_wd, due_wd, stp_wd;
  logic [IW-1:0]     ff_wd;
  logic [TIME_W-1:0] per_q, due_q, stp_q, per_d, due_d, stp_d;
  logic [IW-1:0]     ff_q, ff_d;
  logic [CW:0]       tsum;
  logic [IW-1:0]     tail;
  logic              any_eready, free_f;
  logic [IW-1:0]     free_id;
  logic [1:0]        tgt;

  edf_ram #(.WIDTH(TIME_W), .DEPTH(NUM_TASKS)) u_per (
    .clk, .we(per_we), .waddr(per_wa), .wdata(per_wd), .re, .raddr, .rdata(per_q));
  edf_ram #(.WIDTH(TIME_W), .DEPTH(NUM_TASKS)) u_due (
    .clk, .we(due_we), .waddr(due_wa), .wdata(due_wd), .re, .raddr, .rdata(due_q));
  edf_ram #(.WIDTH(TIME_W), .DEPTH(NUM_TASKS)) u_stp (
    .clk, .we(stp_we), .waddr(stp_wa), .wdata(stp_wd), .re, .raddr, .rdata(stp_q));
  edf_ram #(.WIDTH(IW), .DEPTH(NUM_TASKS)) u_fifo (
    .clk, .we(ff_we), .waddr(ff_wa), .wdata(ff_wd), .re(ff_re), .raddr(head_r),
    .rdata(ff_q));

  // Entries never written read as zero.
  assign per_d = per_ok_r ? per_q : '0;
  assign due_d = due_ok_r ? due_q : '0;
  assign stp_d = stp_ok_r ? stp_q : '0;
  assign ff_d  = ff_ok_r ? ff_q : '0;

  assign tsum = (CW+1)'(head_r) + (CW+1)'(cnt_r);
  assign tail = (tsum >= N_C2) ? IW'(tsum - N_C2) : IW'(tsum);
  assign tgt  = mode_w_r ? PL_WAIT : PL_EREADY;

  always_comb begin
    any_eready = 1'b0;
    free_f     = 1'b0;
    free_id    = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (place_r[i] == PL_EREADY) begin
        any_eready = 1'b1;
      end
      if (!free_f && status_r[i] == ST_UNUSED) begin
        free_f  = 1'b1;
        free_id = IW'(i);
      end
    end
  end

  always_comb begin
    st_nxt       = st_r;
    time_nxt     = time_r;
    stamp_nxt    = stamp_r;
    status_nxt   = status_r;
    place_nxt    = place_r;
    head_nxt     = head_r;
    cnt_nxt      = cnt_r;
    run_v_nxt    = run_v_r;
    run_id_nxt   = run_id_r;
    vper_nxt     = vper_r;
    vdue_nxt     = vdue_r;
    vstp_nxt     = vstp_r;
    vff_nxt      = vff_r;
    scan_nxt     = scan_r;
    cmp_v_nxt    = 1'b0;
    cmp_id_nxt   = cmp_id_r;
    mode_w_nxt   = mode_w_r;
    rel_nxt      = rel_r;
    best_f_nxt   = best_f_r;
    best_id_nxt  = best_id_r;
    best_due_nxt = best_due_r;
    best_per_nxt = best_per_r;
    best_stp_nxt = best_stp_r;
    sw_nxt       = sw_r;
    miss_nxt     = miss_r;
    cok_nxt      = cok_r;
    err_nxt      = err_r;
    cid_nxt      = cid_r;
    item_pop     = 1'b0;
    fin          = 1'b0;
    re           = 1'b0;
    raddr        = run_id_r;
    ff_re        = 1'b0;
    per_we = 1'b0; per_wa = run_id_r; per_wd = item.period;
    due_we = 1'b0; due_wa = run_id_r; due_wd = time_r + item.period;
    stp_we = 1'b0; stp_wa = run_id_r; stp_wd = stamp_r;
    ff_we  = 1'b0; ff_wa  = tail;     ff_wd  = run_id_r;

    case (st_r)
      S_IDLE: begin
        if (item_valid && !out_v_r) begin
          item_pop = 1'b1;
          sw_nxt   = 1'b0;
          miss_nxt = 1'b0;
          cok_nxt  = 1'b0;
          err_nxt  = 1'b0;
          cid_nxt  = '0;
          if ((item.set_period || item.wait_period || item.do_exit) && !run_v_r) begin
            err_nxt = 1'b1;
            fin     = 1'b1;
          end else if (item.tick) begin
            time_nxt = time_r + TIME_W'(step);
            if (enabled) begin
              mode_w_nxt = 1'b1;
              rel_nxt    = 1'b0;
              scan_nxt   = '0;
              best_f_nxt = 1'b0;
              st_nxt     = S_SCAN;
            end else begin
              fin = 1'b1;
            end
          end else if (item.create) begin
            if (free_f) begin
              status_nxt[free_id] = ST_READY;
              cok_nxt = 1'b1;
              cid_nxt = free_id;
              if (cnt_r < N_C) begin
                ff_we              = 1'b1;
                ff_wd              = free_id;
                vff_nxt[tail]      = 1'b1;
                cnt_nxt            = cnt_r + 1'b1;
                place_nxt[free_id] = PL_FIFO;
              end
            end
            fin = 1'b1;
          end else if (item.set_period) begin
            per_we               = 1'b1;
            due_we               = 1'b1;
            vper_nxt[run_id_r]   = 1'b1;
            vdue_nxt[run_id_r]   = 1'b1;
            status_nxt[run_id_r] = ST_RELEASED;
            st_nxt               = S_PUT;
          end else if (item.wait_period) begin
            status_nxt[run_id_r] = ST_WAITING;
            re                   = 1'b1;
            st_nxt               = S_WRD;
          end else if (item.do_exit) begin
            status_nxt[run_id_r] = ST_UNUSED;
            st_nxt               = S_PUT;
          end else if (item.yield) begin
            st_nxt = S_PUT;
          end else begin
            fin = 1'b1;
          end
        end
      end
      S_WRD: begin
        miss_nxt = time_r > due_d;
        st_nxt   = S_PUT;
      end
      S_PUT: begin
        if (run_v_r) begin
          case (status_r[run_id_r])
            ST_READY: begin
              if (cnt_r < N_C) begin
                ff_we               = 1'b1;
                vff_nxt[tail]       = 1'b1;
                cnt_nxt             = cnt_r + 1'b1;
                place_nxt[run_id_r] = PL_FIFO;
              end
            end
            ST_WAITING, ST_RELEASED: begin
              stp_we              = 1'b1;
              vstp_nxt[run_id_r]  = 1'b1;
              stamp_nxt           = stamp_r + 1'b1;
              place_nxt[run_id_r] = (status_r[run_id_r] == ST_WAITING) ? PL_WAIT : PL_EREADY;
            end
            default: begin
            end
          endcase
        end
        mode_w_nxt = 1'b0;
        scan_nxt   = '0;
        best_f_nxt = 1'b0;
        st_nxt     = S_SCAN;
      end
      S_SCAN: begin
        ff_re = 1'b1;
        if (cmp_v_r && place_r[cmp_id_r] == tgt) begin
          if (!best_f_r || due_d < best_due_r ||
              (due_d == best_due_r && (stamp_r - stp_d) > (stamp_r - best_stp_r))) begin
            best_f_nxt   = 1'b1;
            best_id_nxt  = cmp_id_r;
            best_due_nxt = due_d;
            best_per_nxt = per_d;
            best_stp_nxt = stp_d;
          end
        end
        if (scan_r < N_C) begin
          re         = 1'b1;
          raddr      = scan_r[IW-1:0];
          cmp_v_nxt  = 1'b1;
          cmp_id_nxt = scan_r[IW-1:0];
          scan_nxt   = scan_r + 1'b1;
        end else if (!cmp_v_r) begin
          st_nxt = S_END;
        end
      end
      S_END: begin
        if (mode_w_r) begin
          if (best_f_r && time_r >= best_due_r) begin
            status_nxt[best_id_r] = ST_RELEASED;
            place_nxt[best_id_r]  = PL_EREADY;
            due_we                = 1'b1;
            due_wa                = best_id_r;
            due_wd                = best_due_r + best_per_r;
            stp_we                = 1'b1;
            stp_wa                = best_id_r;
            vdue_nxt[best_id_r]   = 1'b1;
            vstp_nxt[best_id_r]   = 1'b1;
            stamp_nxt             = stamp_r + 1'b1;
            rel_nxt               = 1'b1;
            scan_nxt              = '0;
            best_f_nxt            = 1'b0;
            st_nxt                = S_SCAN;
          end else if (rel_r || !any_eready) begin
            st_nxt = S_PUT;
          end else begin
            fin = 1'b1;
          end
        end else begin
          if (best_f_r) begin
            place_nxt[best_id_r] = PL_NONE;
            run_v_nxt            = 1'b1;
            run_id_nxt           = best_id_r;
            sw_nxt               = 1'b1;
          end else if (cnt_r != '0) begin
            place_nxt[ff_d] = PL_NONE;
            head_nxt        = (head_r == IW'(NUM_TASKS - 1)) ? '0 : head_r + 1'b1;
            cnt_nxt         = cnt_r - 1'b1;
            run_v_nxt       = 1'b1;
            run_id_nxt      = ff_d;
            sw_nxt          = 1'b1;
          end else begin
            run_v_nxt  = 1'b0;
            run_id_nxt = '0;
            sw_nxt     = 1'b0;
          end
          fin = 1'b1;
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    if (fin) begin
      st_nxt = S_IDLE;
    end

    out_nxt                 = out_r;
    out_v_nxt               = out_v_r && !res_pop;
    if (fin) begin
      out_v_nxt               = 1'b1;
      out_nxt.active_valid    = run_v_nxt;
      out_nxt.active_id       = run_v_nxt ? OUT_ID_W'(run_id_nxt) : '0;
      out_nxt.switched        = sw_nxt;
      out_nxt.deadline_missed = miss_nxt;
      out_nxt.create_ok       = cok_nxt;
      out_nxt.created_id      = OUT_ID_W'(cid_nxt);
      out_nxt.now_time        = time_nxt;
      out_nxt.command_error   = err_nxt;
    end
  end

  assign res_valid = out_v_r;
  assign res       = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      time_r   <= '0;
      stamp_r  <= TIME_W'(1);
      head_r   <= '0;
      cnt_r    <= CW'(1);
      run_v_r  <= 1'b0;
      run_id_r <= '0;
      vper_r   <= '0;
      vdue_r   <= '0;
      vstp_r   <= '0;
      vff_r    <= '0;
      cmp_v_r  <= 1'b0;
      out_v_r  <= 1'b0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        status_r[i] <= (i == 0) ? ST_READY : ST_UNUSED;
        place_r[i]  <= (i == 0) ? PL_FIFO : PL_NONE;
      end
    end else begin
      st_r     <= st_nxt;
      time_r   <= time_nxt;
      stamp_r  <= stamp_nxt;
      head_r   <= head_nxt;
      cnt_r    <= cnt_nxt;
      run_v_r  <= run_v_nxt;
      run_id_r <= run_id_nxt;
      vper_r   <= vper_nxt;
      vdue_r   <= vdue_nxt;
      vstp_r   <= vstp_nxt;
      vff_r    <= vff_nxt;
      cmp_v_r  <= cmp_v_nxt;
      out_v_r  <= out_v_nxt;
      status_r <= status_nxt;
      place_r  <= place_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    cmp_id_r   <= cmp_id_nxt;
    mode_w_r   <= mode_w_nxt;
    rel_r      <= rel_nxt;
    best_f_r   <= best_f_nxt;
    best_id_r  <= best_id_nxt;
    best_due_r <= best_due_nxt;
    best_per_r <= best_per_nxt;
    best_stp_r <= best_stp_nxt;
    sw_r       <= sw_nxt;
    miss_r     <= miss_nxt;
    cok_r      <= cok_nxt;
    err_r      <= err_nxt;
    cid_r      <= cid_nxt;
    out_r      <= out_nxt;
    if (re) begin
      per_ok_r <= vper_r[raddr];
      due_ok_r <= vdue_r[raddr];
      stp_ok_r <= vstp_r[raddr];
    end
    if (ff_re) begin
      ff_ok_r <= vff_r[head_r];
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= N_C) else $error("ready queue count exceeds slot count");
  a_idle_id: assert property (@(posedge clk) disable iff (!rst_n)
    !run_v_r |-> run_id_r == '0) else $error("running id set with no task running");
  // While the engine is idle the running task sits in no queue.
  a_run_place: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE && run_v_r) |-> place_r[run_id_r] == PL_NONE)
    else $error("running task still queued");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> !out_v_r) else $error("result finished while output slot busy");
`endif

endmodule

@@ design/edf_periodic_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// EDF periodic task scheduler
// Earliest-deadline-first scheduler with a FIFO fallback for plain tasks.
// ----------------------------------------------------------------------------
// Usage: commands enter through a queue-style port (push/full, in_cmd and
// in_period); a beat is taken when push is high and full is low. Results
// leave through a second queue-style port: while empty is low the oldest
// result sits on the out_ ports, and it is taken when pop is high. Every
// command yields exactly one result beat.
// Work per command, with the engine idle: create, unknown commands, errors
// and disabled ticks finish as soon as the command is taken. Yield, set
// period and exit take the command, put the running task back, walk the
// task table through the registered memories and pick. Wait also reads the
// due time first. An enabled tick walks the table once per release and once
// more to find none due; when a decision follows, it then puts the running
// task back and walks the table again to pick. One command is worked on at
// a time; the single read port of the task memories sets the pace of each
// walk.
// Reset: slot 0 is ready in the FIFO, nothing runs, time is zero, the
// scheduler is disabled and the tick step is 10.
// Stall: a two-entry command queue keeps accepting while one result waits;
// the engine holds further work until the result beat is taken.
// ----------------------------------------------------------------------------
module edf_periodic_task_scheduler
  import edf_pkg::*;
#(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [TIME_W-1:0]   in_period,
  output logic                empty,
  input  logic                pop,
  output logic                out_active_valid,
  output logic [OUT_ID_W-1:0] out_active_id,
  output logic                out_switched,
  output logic                out_deadline_missed,
  output logic                out_create_ok,
  output logic [OUT_ID_W-1:0] out_created_id,
  output logic [TIME_W-1:0]   out_now_time,
  output logic                out_command_error,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [CFG_DW-1:0]   pwdata,
  output logic [CFG_DW-1:0]   prdata,
  output logic                pready
);

  // Configuration registers at addresses 0 (enable) and 4 (tick step); the user
  // must write them only while the block is idle, the block does not enforce it.
  logic              en_r, en_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              cfg_wr;

  // Front to back handoff
  logic item_valid, item_pop;
  cmd_t item;
  logic res_valid;
  res_t res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    en_nxt   = en_r;
    step_nxt = step_r;
    if (cfg_wr) begin
      case (paddr[2])
        REG_ENABLE: en_nxt   = pwdata[0];
        REG_STEP:   step_nxt = pwdata[STEP_W-1:0];
        default:    en_nxt   = en_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ENABLE: prdata = CFG_DW'(en_r);
      REG_STEP:   prdata = CFG_DW'(step_r);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b0;
      step_r <= TICK_STEP_RST;
    end else begin
      en_r   <= en_nxt;
      step_r <= step_nxt;
    end
  end

  // Front end: takes command beats and decodes them into the queue.
  edf_front u_front (
    .clk,
    .rst_n,
    .push,
    .cmd        (in_cmd),
    .period     (in_period),
    .full,
    .item_valid,
    .item,
    .item_pop
  );

  // Back end: runs the scheduling work and holds the finished result.
  edf_back #(.NUM_TASKS(NUM_TASKS)) u_back (
    .clk,
    .rst_n,
    .item_valid,
    .item,
    .item_pop,
    .enabled   (en_r),
    .step      (step_r),
    .res_valid,
    .res,
    .res_pop   (pop)
  );

  assign empty               = !res_valid;
  assign out_active_valid    = res.active_valid;
  assign out_active_id       = res.active_id;
  assign out_switched        = res.switched;
  assign out_deadline_missed = res.deadline_missed;
  assign out_create_ok       = res.create_ok;
  assign out_created_id      = res.created_id;
  assign out_now_time        = res.now_time;
  assign out_command_error   = res.command_error;

endmodule

@@ bench/edf_periodic_task_scheduler_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDF periodic task scheduler testbench
// Drives scheduler commands through the queue-style input, predicts each
// result beat with a behavioral scheduler model kept in the bench, and checks
// every beat field by field. Both configuration registers are written over
// several phases, including their extremes.
// ----------------------------------------------------------------------------
module edf_periodic_task_scheduler_tb;
  import edf_pkg::*;

  localparam int NT = 8;
  localparam int WATCHDOG_LIMIT = 20000;

  logic                clk;
  logic                rst_n;
  logic                push;
  logic                full;
  logic [CMD_W-1:0]    in_cmd;
  logic [TIME_W-1:0]   in_period;
  logic                empty;
  logic                pop;
  logic                out_active_valid;
  logic [OUT_ID_W-1:0] out_active_id;
  logic                out_switched;
  logic                out_deadline_missed;
  logic                out_create_ok;
  logic [OUT_ID_W-1:0] out_created_id;
  logic [TIME_W-1:0]   out_now_time;
  logic                out_command_error;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  edf_periodic_task_scheduler i_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_cmd(in_cmd),
    .in_period(in_period), .empty(empty), .pop(pop),
    .out_active_valid(out_active_valid), .out_active_id(out_active_id),
    .out_switched(out_switched), .out_deadline_missed(out_deadline_missed),
    .out_create_ok(out_create_ok), .out_created_id(out_created_id),
    .out_now_time(out_now_time), .out_command_error(out_command_error),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Shadow copy of the scheduler state, updated once per accepted command and on each register write.
  logic              sh_enabled;
  logic [STEP_W-1:0] sh_step;
  logic [TIME_W-1:0] sh_time;
  logic [1:0]        sh_status[NT];
  logic [1:0]        sh_place[NT];
  logic [31:0]       sh_period[NT];
  logic [31:0]       sh_due[NT];
  logic [31:0]       sh_stamp[NT];
  logic [31:0]       sh_stamp_ctr;
  logic [2:0]        sh_fifo[NT];
  logic [2:0]        sh_head;
  int                sh_count;
  logic              sh_run_valid;
  logic [2:0]        sh_run_id;

  res_t expected_beats[$];
  bit   failed;
  int   idle_cycles;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   recv_hold;

  function automatic void shadow_reset();
    sh_enabled = 1'b0;
    sh_step = TICK_STEP_RST;
    sh_time = '0;
    for (int i = 0; i < NT; i++) begin
      sh_status[i] = ST_UNUSED;
      sh_place[i] = PL_NONE;
      sh_period[i] = '0;
      sh_due[i] = '0;
      sh_stamp[i] = '0;
      sh_fifo[i] = '0;
    end
    sh_status[0] = ST_READY;
    sh_place[0] = PL_FIFO;
    sh_stamp_ctr = 32'd1;
    sh_head = '0;
    sh_count = 1;
    sh_run_valid = 1'b0;
    sh_run_id = '0;
  endfunction

  function automatic void fifo_append(int id);
    if (sh_count < NT) begin
      sh_fifo[3'(sh_head + sh_count)] = 3'(id);
      sh_count++;
      sh_place[id] = PL_FIFO;
    end
  endfunction

  function automatic void queue_insert(int id, logic [1:0] pl);
    sh_place[id] = pl;
    sh_stamp[id] = sh_stamp_ctr;
    sh_stamp_ctr++;
  endfunction

  // Earliest due time in the given queue; equal due times go to the older entry.
  function automatic int earliest_in(logic [1:0] pl);
    int best;
    logic [31:0] age_i, age_b;
    best = -1;
    for (int i = 0; i < NT; i++) begin
      if (sh_place[i] == pl) begin
        if (best < 0) begin
          best = i;
        end else begin
          age_i = sh_stamp_ctr - sh_stamp[i];
          age_b = sh_stamp_ctr - sh_stamp[best];
          if (sh_due[i] < sh_due[best] || (sh_due[i] == sh_due[best] && age_i > age_b))
            best = i;
        end
      end
    end
    return best;
  endfunction

  function automatic bit pick_next_task();
    int nxt;
    if (sh_run_valid) begin
      case (sh_status[sh_run_id])
        ST_READY:    fifo_append(sh_run_id);
        ST_WAITING:  queue_insert(sh_run_id, PL_WAIT);
        ST_RELEASED: queue_insert(sh_run_id, PL_EREADY);
        default: ;
      endcase
    end
    nxt = earliest_in(PL_EREADY);
    if (nxt >= 0) begin
      sh_place[nxt] = PL_NONE;
    end else if (sh_count > 0) begin
      nxt = sh_fifo[sh_head];
      sh_head = sh_head + 3'd1;
      sh_count--;
      sh_place[nxt] = PL_NONE;
    end
    if (nxt >= 0) begin
      sh_run_valid = 1'b1;
      sh_run_id = 3'(nxt);
      return 1'b1;
    end
    sh_run_valid = 1'b0;
    sh_run_id = '0;
    return 1'b0;
  endfunction

  function automatic res_t schedule_command(logic [CMD_W-1:0] cmd, logic [31:0] per);
    res_t r;
    int t;
    bit rel;
    r = '0;
    if ((cmd == CMD_SETP || cmd == CMD_WAIT || cmd == CMD_EXIT) && !sh_run_valid) begin
      r.command_error = 1'b1;
    end else begin
      case (cmd)
        CMD_TICK: begin
          sh_time = sh_time + sh_step;
          if (sh_enabled) begin
            rel = 1'b0;
            forever begin
              t = earliest_in(PL_WAIT);
              if (t < 0 || sh_time < sh_due[t]) break;
              rel = 1'b1;
              sh_status[t] = ST_RELEASED;
              sh_due[t] = sh_due[t] + sh_period[t];
              queue_insert(t, PL_EREADY);
            end
            if (rel || earliest_in(PL_EREADY) < 0) r.switched = pick_next_task();
          end
        end
        CMD_CREATE: begin
          for (int i = 0; i < NT; i++) begin
            if (sh_status[i] == ST_UNUSED) begin
              sh_status[i] = ST_READY;
              fifo_append(i);
              r.create_ok = 1'b1;
              r.created_id = 3'(i);
              break;
            end
          end
        end
        CMD_SETP: begin
          sh_period[sh_run_id] = per;
          sh_due[sh_run_id] = sh_time + per;
          sh_status[sh_run_id] = ST_RELEASED;
          r.switched = pick_next_task();
        end
        CMD_WAIT: begin
          sh_status[sh_run_id] = ST_WAITING;
          r.deadline_missed = sh_time > sh_due[sh_run_id];
          r.switched = pick_next_task();
        end
        CMD_EXIT: begin
          sh_status[sh_run_id] = ST_UNUSED;
          r.switched = pick_next_task();
        end
        CMD_YIELD: r.switched = pick_next_task();
        default: ;
      endcase
    end
    r.active_valid = sh_run_valid;
    r.active_id = sh_run_valid ? sh_run_id : 3'd0;
    r.now_time = sh_time;
    return r;
  endfunction

  // Result side: pop with a random duty, unless a long hold-off is in force.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      pop <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && pop && !empty) begin
      idle_cycles = 0;
      if (expected_beats.size() == 0) begin
        failed = 1'b1;
        $display("%0t: result beat with nothing expected", $realtime);
      end else begin
        want = expected_beats.pop_front();
        if (out_active_valid !== want.active_valid ||
            out_active_id !== want.active_id ||
            out_switched !== want.switched ||
            out_deadline_missed !== want.deadline_missed ||
            out_create_ok !== want.create_ok ||
            out_created_id !== want.created_id ||
            out_now_time !== want.now_time ||
            out_command_error !== want.command_error) begin
          failed = 1'b1;
          $display("%0t: mismatch expected av=%0d id=%0d sw=%0d dm=%0d ok=%0d cid=%0d t=%0d err=%0d",
                   $realtime, want.active_valid, want.active_id, want.switched,
                   want.deadline_missed, want.create_ok, want.created_id,
                   want.now_time, want.command_error);
          $display("%0t:          actual   av=%0d id=%0d sw=%0d dm=%0d ok=%0d cid=%0d t=%0d err=%0d",
                   $realtime, out_active_valid, out_active_id, out_switched,
                   out_deadline_missed, out_create_ok, out_created_id,
                   out_now_time, out_command_error);
        end
      end
    end
  end

  // Watchdog: any stretch without an accepted beat of either kind is bounded.
  always @(posedge clk) begin
    if (rst_n) begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[edf_periodic_task_scheduler] ERROR");
        $finish;
      end
    end
  end

  // Offer one command beat; the prediction is made when the beat is taken.
  // push stays high after a taken beat until the next idle cycle or drain,
  // so that it is never assigned twice in one time step.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [31:0] per, bit idle_ok);
    while (idle_ok && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_cmd <= cmd;
    in_period <= per;
    do @(posedge clk); while (full);
    expected_beats.push_back(schedule_command(cmd, per));
    idle_cycles = 0;
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    // Let the engine settle before touching the registers.
    repeat (40) @(posedge clk);
  endtask

  task automatic write_register(logic idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_ENABLE) sh_enabled = value[0];
    else sh_step = value[STEP_W-1:0];
    idle_cycles = 0;
  endtask

  // Directed rows. Expected values are typed in for the rows that follow
  // straight from reset; the rest have typed_in clear and use the predictor.
  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [31:0]      per;
    bit               typed_in;
    res_t             want;
  } dir_row_t;

  dir_row_t directed_rows[] = '{
    // With nothing running, set period, wait and exit are refused.
    '{CMD_SETP,  32'd5, 1'b1, '{1'b0, 3'd0, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0, 1'b1}},
    '{CMD_WAIT,  32'd0, 1'b1, '{1'b0, 3'd0, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0, 1'b1}},
    '{CMD_EXIT,  32'd0, 1'b1, '{1'b0, 3'd0, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0, 1'b1}},
    // A disabled tick only counts time by the reset step.
    '{CMD_TICK,  32'd0, 1'b1, '{1'b0, 3'd0, 1'b0, 1'b0, 1'b0, 3'd0, 32'd10, 1'b0}},
    // Unknown codes only report the time.
    '{3'd6,      32'hFFFF_FFFF, 1'b1, '{1'b0, 3'd0, 1'b0, 1'b0, 1'b0, 3'd0, 32'd10, 1'b0}},
    '{3'd7,      32'd0, 1'b1, '{1'b0, 3'd0, 1'b0, 1'b0, 1'b0, 3'd0, 32'd10, 1'b0}},
    // Yield with nothing running still picks the FIFO head, slot 0.
    '{CMD_YIELD, 32'd0, 1'b1, '{1'b1, 3'd0, 1'b1, 1'b0, 1'b0, 3'd0, 32'd10, 1'b0}},
    '{CMD_CREATE, 32'd0, 1'b1, '{1'b1, 3'd0, 1'b0, 1'b0, 1'b1, 3'd1, 32'd10, 1'b0}},
    // Fill the table until a create finds no free slot.
    '{CMD_CREATE, 32'd0, 1'b0, '{default: '0}},
    '{CMD_CREATE, 32'd0, 1'b0, '{default: '0}},
    '{CMD_CREATE, 32'd0, 1'b0, '{default: '0}},
    '{CMD_CREATE, 32'd0, 1'b0, '{default: '0}},
    '{CMD_CREATE, 32'd0, 1'b0, '{default: '0}},
    '{CMD_CREATE, 32'd0, 1'b0, '{default: '0}},
    '{CMD_CREATE, 32'd0, 1'b0, '{default: '0}},
    // Periodic tasks, including the largest period and a zero period.
    '{CMD_SETP,  32'hFFFF_FFFF, 1'b0, '{default: '0}},
    '{CMD_SETP,  32'd0, 1'b0, '{default: '0}},
    '{CMD_SETP,  32'd15, 1'b0, '{default: '0}},
    '{CMD_WAIT,  32'd0, 1'b0, '{default: '0}},
    '{CMD_TICK,  32'd0, 1'b0, '{default: '0}},
    '{CMD_YIELD, 32'd0, 1'b0, '{default: '0}},
    '{CMD_WAIT,  32'd0, 1'b0, '{default: '0}},
    '{CMD_EXIT,  32'd0, 1'b0, '{default: '0}},
    '{CMD_TICK,  32'd0, 1'b0, '{default: '0}}
  };

  // Random command mix: mostly scheduling traffic with periodic tasks.
  task automatic random_command(bit idle_ok);
    int pick;
    logic [31:0] per;
    pick = $urandom_range(99);
    per = ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(60));
    if (pick < 30)      send_command(CMD_TICK, per, idle_ok);
    else if (pick < 42) send_command(CMD_CREATE, per, idle_ok);
    else if (pick < 56) send_command(CMD_SETP, per, idle_ok);
    else if (pick < 72) send_command(CMD_WAIT, per, idle_ok);
    else if (pick < 80) send_command(CMD_EXIT, per, idle_ok);
    else if (pick < 96) send_command(CMD_YIELD, per, idle_ok);
    else                send_command(3'($urandom_range(7)), per, idle_ok);
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_cmd = CMD_TICK;
    in_period = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    failed = 1'b0;
    idle_cycles = 0;
    send_idle_pct = 21;
    recv_idle_pct = 82;
    recv_hold = 1'b0;
    shadow_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset settings, then enable and repeat the predicted rows with a step of 1.
    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].cmd, directed_rows[i].per, 1'b1);
      if (directed_rows[i].typed_in) expected_beats[$] = directed_rows[i].want;
    end
    drain_results();
    write_register(REG_ENABLE, 32'd1);
    write_register(REG_STEP, 32'd1);
    foreach (directed_rows[i])
      if (!directed_rows[i].typed_in) send_command(directed_rows[i].cmd, directed_rows[i].per, 1'b1);

    // Random phases over several register settings and idling patterns.
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      case (ph)
        0: write_register(REG_STEP, 32'd7);
        1: write_register(REG_STEP, 32'd65535);
        2: write_register(REG_ENABLE, 32'd0);
        3: begin
          write_register(REG_ENABLE, 32'd1);
          write_register(REG_STEP, 32'd0);
        end
        4: write_register(REG_STEP, 32'($urandom_range(1, 40)));
        default: write_register(REG_STEP, 32'd3);
      endcase
      if (ph == 2) begin
        send_idle_pct = 82;
        recv_idle_pct = 21;
      end else if (ph >= 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == 1) begin
        // Long receiver hold-off while commands keep coming, so input stalls.
        fork
          begin
            recv_hold = 1'b1;
            repeat (300) @(posedge clk);
            recv_hold = 1'b0;
          end
          repeat (10) random_command(1'b0);
        join
      end
      for (int n = 0; n < 100; n++) random_command(1'b1);
    end

    drain_results();
    if (!failed) begin
      $display("[edf_periodic_task_scheduler] OK");
    end else begin
      $display("[edf_periodic_task_scheduler] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/edf_pkg.sv
design/edf_ram.sv
design/edf_front.sv
design/edf_back.sv
design/edf_periodic_task_scheduler.sv
bench/edf_periodic_task_scheduler_tb.sv
